>>> hdl/qaar_pkg.sv
package qaar_pkg;

    // Field formats
    localparam int COORD_WIDTH = 32;
    localparam int COORD_FRAC_BITS = 16;
    localparam int ANGLE_BITS = 16;
    localparam int LIMIT_WIDTH = 32;

    // Quaternion components carry 30 fraction bits
    localparam int QF = 30;

    // CORDIC datapath width and start value (0.607252935 * 2^30)
    localparam int CW = 34;
    localparam int ATAN_COUNT = 30;
    localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;

    // Arctangent of 2^-i as a fraction of a turn, 2^32 = one turn
    localparam logic [31:0] ATAN_TURN32 [ATAN_COUNT] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
        32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
        32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
        32'd20, 32'd10, 32'd5, 32'd3, 32'd1
    };

    // Step counts of the square root and divider cell rows
    localparam int SQRT_STEPS = 31;
    localparam int DIV_STEPS = 31;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    // Data handed between CORDIC cells
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic [1:0]           quad;
    } cordic_t;

    // Data handed between square root cells
    typedef struct packed {
        logic [61:0] rem;
        logic [62:0] root;
    } sqrt_t;

    // Data handed between divider cells
    typedef struct packed {
        logic [60:0] rem;
        logic [30:0] divisor;
        logic [30:0] quo;
    } div_t;

    // round(a * c / 2^QF), halves away from zero
    function automatic logic signed [38:0] mul_q(input logic signed [35:0] a,
                                                 input logic signed [31:0] c);
        logic [35:0] ua;
        logic [31:0] uc;
        logic [67:0] full;
        logic [37:0] mag;
        ua = a[35] ? 36'(-a) : 36'(a);
        uc = c[31] ? 32'(-c) : 32'(c);
        full = 68'(ua) * 68'(uc);
        mag = 38'((full + (68'd1 << (QF - 1))) >> QF);
        if (a[35] ^ c[31])
        begin
            mul_q = -$signed({1'b0, mag});
        end
        else
        begin
            mul_q = $signed({1'b0, mag});
        end
    endfunction

endpackage

>>> hdl/qaar_in_if.sv
interface qaar_in_if;
    logic valid;
    logic ready;
    logic signed [qaar_pkg::COORD_WIDTH-1:0] point_x;
    logic signed [qaar_pkg::COORD_WIDTH-1:0] point_y;
    logic signed [qaar_pkg::COORD_WIDTH-1:0] point_z;
    logic [qaar_pkg::ANGLE_BITS-1:0]         turn_angle;
    logic signed [qaar_pkg::COORD_WIDTH-1:0] axis_x;
    logic signed [qaar_pkg::COORD_WIDTH-1:0] axis_y;
    logic signed [qaar_pkg::COORD_WIDTH-1:0] axis_z;

    modport source (
        output valid, point_x, point_y, point_z, turn_angle, axis_x, axis_y, axis_z,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, point_z, turn_angle, axis_x, axis_y, axis_z,
        output ready
    );
endinterface

>>> hdl/qaar_out_if.sv
interface qaar_out_if;
    logic valid;
    logic ready;
    logic signed [qaar_pkg::COORD_WIDTH-1:0] rotated_x;
    logic signed [qaar_pkg::COORD_WIDTH-1:0] rotated_y;
    logic signed [qaar_pkg::COORD_WIDTH-1:0] rotated_z;
    logic                                    axis_was_zero;
    logic                                    saturated;

    modport source (
        output valid, rotated_x, rotated_y, rotated_z, axis_was_zero, saturated,
        input  ready
    );
    modport sink (
        input  valid, rotated_x, rotated_y, rotated_z, axis_was_zero, saturated,
        output ready
    );
endinterface

>>> hdl/qaar_cordic_cell.sv
module qaar_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic              clk,
    input  logic              en,
    input  qaar_pkg::cordic_t d_in,
    output qaar_pkg::cordic_t d_out
);
    localparam int CW = qaar_pkg::CW;
    localparam logic signed [CW-1:0] STEP_ANGLE = CW'(qaar_pkg::ATAN_TURN32[STAGE]);

    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    qaar_pkg::cordic_t    rot_reg;
    qaar_pkg::cordic_t    rot_next;

    // Shifted cross terms, rounding toward minus infinity
    assign dx = $signed(d_in.y) >>> STAGE;
    assign dy = $signed(d_in.x) >>> STAGE;

    // One micro-rotation toward a zero residual angle
    always_comb
    begin
        rot_next.quad = d_in.quad;
        if (!d_in.z[CW-1])
        begin
            rot_next.x = d_in.x - dx;
            rot_next.y = d_in.y + dy;
            rot_next.z = d_in.z - STEP_ANGLE;
        end
        else
        begin
            rot_next.x = d_in.x + dx;
            rot_next.y = d_in.y - dy;
            rot_next.z = d_in.z + STEP_ANGLE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rot_reg <= rot_next;
        end
    end

    assign d_out = rot_reg;
endmodule

>>> hdl/qaar_sqrt_cell.sv
module qaar_sqrt_cell #(
    parameter int K = 0
) (
    input  logic            clk,
    input  logic            en,
    input  qaar_pkg::sqrt_t d_in,
    output qaar_pkg::sqrt_t d_out
);
    localparam logic [62:0] ONE = 63'(1) << (2 * K);

    logic [62:0]     trial;
    logic            fits;
    qaar_pkg::sqrt_t sq_reg;
    qaar_pkg::sqrt_t sq_next;

    // One bit of the restoring integer square root
    assign trial = d_in.root + ONE;
    assign fits  = {1'b0, d_in.rem} >= trial;

    always_comb
    begin
        if (fits)
        begin
            sq_next.rem  = d_in.rem - trial[61:0];
            sq_next.root = (d_in.root >> 1) + ONE;
        end
        else
        begin
            sq_next.rem  = d_in.rem;
            sq_next.root = d_in.root >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg <= sq_next;
        end
    end

    assign d_out = sq_reg;
endmodule

>>> hdl/qaar_div_cell.sv
module qaar_div_cell #(
    parameter int BIT = 0
) (
    input  logic           clk,
    input  logic           en,
    input  qaar_pkg::div_t d_in,
    output qaar_pkg::div_t d_out
);
    logic [60:0]    shifted;
    logic           fits;
    qaar_pkg::div_t dv_reg;
    qaar_pkg::div_t dv_next;

    // One quotient bit of a restoring division
    assign shifted = 61'(d_in.divisor) << BIT;
    assign fits    = d_in.rem >= shifted;

    always_comb
    begin
        dv_next          = d_in;
        dv_next.quo[BIT] = fits;
        if (fits)
        begin
            dv_next.rem = d_in.rem - shifted;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_reg <= dv_next;
        end
    end

    assign d_out = dv_reg;
endmodule

>>> hdl/quaternion_axis_angle_rotate.sv
// Channel   Direction  Handshake        Payload
// item_in   request    valid / ready    point_x/y/z, turn_angle, axis_x/y/z
// item_out  result     valid / ready    rotated_x/y/z, axis_was_zero, saturated
// cfg       write      cfg_we           cfg_wdata -> zero_axis_limit
//
// One request is taken per clock unless item_out is stalled.
// The pipeline depth is dominated by the 31-cell square root row and the 31-cell divider row in series.
// rst_n clears the valid bits and sets zero_axis_limit to 1; data registers are not reset.
// When item_out is stalled the whole pipeline holds and item_in.ready drops.
module quaternion_axis_angle_rotate #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [qaar_pkg::LIMIT_WIDTH-1:0]     cfg_wdata,
    qaar_in_if.sink                              item_in,
    qaar_out_if.source                           item_out
);
    localparam int CW = qaar_pkg::CW;
    localparam int PW = qaar_pkg::COORD_WIDTH;

    // Pipeline positions, counted from the capture register
    localparam int T_SQRT_IN = 5;
    localparam int T_SQRT_OUT = T_SQRT_IN + qaar_pkg::SQRT_STEPS;
    localparam int T_DIV_OUT = T_SQRT_OUT + 1 + qaar_pkg::DIV_STEPS;
    localparam int LAST = T_DIV_OUT + 5;
    localparam int SIDE_DEPTH = T_DIV_OUT - 2;
    localparam int NM_DEPTH = T_SQRT_OUT - 3;
    localparam int CQ_DEPTH = T_DIV_OUT - CORDIC_STAGES;

    // Operand selection for the two Hamilton product stages
    localparam int PI_SEL [12] = '{0, 1, 2, 0, 2, 1, 1, 0, 2, 2, 1, 0};
    localparam int QI_SEL [12] = '{1, 2, 3, 0, 2, 3, 0, 3, 1, 0, 1, 2};
    localparam int RI_SEL [12] = '{0, 1, 2, 3, 0, 2, 3, 1, 0, 3, 1, 2};
    localparam int QK_SEL [12] = '{1, 0, 3, 2, 2, 0, 1, 3, 3, 0, 2, 1};

    typedef logic [2:0][29:0] nm3_t;

    typedef struct packed {
        logic [2:0][PW-1:0] pnt;
        logic [2:0]         neg;
        logic               zero;
    } side_t;

    typedef struct packed {
        logic signed [31:0] qw;
        logic signed [31:0] qs;
    } cs_t;

    logic                            en;
    logic [LAST:0]                   vld_reg;
    logic [qaar_pkg::LIMIT_WIDTH-1:0] limit_reg;

    // Capture stage
    qaar_pkg::coord_t                pnt_a_reg [3];
    qaar_pkg::coord_t                ax_a_reg [3];
    logic [qaar_pkg::ANGLE_BITS-1:0] ang_a_reg;

    // Axis magnitude and zero test stages
    logic [31:0]      mag_next [3];
    logic [31:0]      mag_b_reg [3];
    logic [63:0]      sq_b_reg [3];
    qaar_pkg::coord_t pnt_b_reg [3];
    logic [2:0]       neg_b_reg;
    logic [63:0]      sum_c;
    logic [31:0]      max_c;
    side_t            side_c_reg;
    logic [31:0]      mag_c_reg [3];
    logic [31:0]      max_c_reg;

    // Normalizing shift and squared length
    logic [4:0]  top_bit;
    nm3_t        nm_next;
    nm3_t        nm_d_reg;
    logic [59:0] sqn_e_reg [3];
    logic [61:0] sum2_f_reg;
    nm3_t        nm_line_reg [NM_DEPTH];
    side_t       side_line_reg [SIDE_DEPTH];

    qaar_pkg::sqrt_t slink [qaar_pkg::SQRT_STEPS+1];
    qaar_pkg::div_t  dlink [3][qaar_pkg::DIV_STEPS+1];
    qaar_pkg::div_t  div_g_reg [3];
    logic [30:0]     len_g;

    // Half-angle sine and cosine
    logic [31:0]       phase;
    logic [1:0]        quad;
    logic [31:0]       resid;
    qaar_pkg::cordic_t clink [CORDIC_STAGES+1];
    qaar_pkg::cordic_t cend;
    cs_t               cs_map;
    cs_t               cq_line_reg [CQ_DEPTH];

    // Quaternion and rotation stages
    logic signed [38:0] qv_h [3];
    logic signed [31:0] q_h_reg [4];
    qaar_pkg::coord_t   pnt_h_reg [3];
    logic               zero_h_reg;
    logic signed [38:0] m_i_reg [12];
    logic signed [31:0] q_i_reg [4];
    qaar_pkg::coord_t   pnt_i_reg [3];
    logic               zero_i_reg;
    logic signed [40:0] r_sum [4];
    logic signed [35:0] r_j_reg [4];
    logic signed [31:0] q_j_reg [4];
    qaar_pkg::coord_t   pnt_j_reg [3];
    logic               zero_j_reg;
    logic signed [38:0] n_k_reg [12];
    qaar_pkg::coord_t   pnt_k_reg [3];
    logic               zero_k_reg;
    logic signed [40:0] res_sum [3];
    logic [PW-1:0]      clip_val [3];
    logic [2:0]         clip_hit;
    logic [PW-1:0]      rot_reg [3];
    logic               wz_reg;
    logic               sat_reg;

    // Global advance: the pipeline moves unless a result waits
    assign en            = !vld_reg[LAST] || item_out.ready;
    assign item_in.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            limit_reg <= qaar_pkg::LIMIT_WIDTH'(1);
        end
        else
        begin
            if (en)
            begin
                vld_reg <= {vld_reg[LAST-1:0], item_in.valid};
            end
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    // Capture the request
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pnt_a_reg[0] <= item_in.point_x;
            pnt_a_reg[1] <= item_in.point_y;
            pnt_a_reg[2] <= item_in.point_z;
            ax_a_reg[0]  <= item_in.axis_x;
            ax_a_reg[1]  <= item_in.axis_y;
            ax_a_reg[2]  <= item_in.axis_z;
            ang_a_reg    <= item_in.turn_angle;
        end
    end

    // Axis magnitudes and their squares
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            mag_next[l] = ax_a_reg[l][PW-1] ? 32'(-ax_a_reg[l]) : 32'(ax_a_reg[l]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 3; l++)
            begin
                mag_b_reg[l]  <= mag_next[l];
                sq_b_reg[l]   <= 64'(mag_next[l]) * 64'(mag_next[l]);
                pnt_b_reg[l]  <= pnt_a_reg[l];
                neg_b_reg[l]  <= ax_a_reg[l][PW-1];
            end
        end
    end

    // Zero axis test and largest magnitude
    assign sum_c = sq_b_reg[0] + sq_b_reg[1] + sq_b_reg[2];

    always_comb
    begin
        max_c = mag_b_reg[0];
        if (mag_b_reg[1] > max_c)
        begin
            max_c = mag_b_reg[1];
        end
        if (mag_b_reg[2] > max_c)
        begin
            max_c = mag_b_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 3; l++)
            begin
                side_c_reg.pnt[l] <= pnt_b_reg[l];
                mag_c_reg[l]      <= mag_b_reg[l];
            end
            side_c_reg.neg  <= neg_b_reg;
            side_c_reg.zero <= (sum_c == 64'd0) ||
                               (sum_c < {16'd0, limit_reg, 16'd0});
            max_c_reg       <= max_c;
        end
    end

    // Shift all magnitudes together so the largest lands in [2^29, 2^30)
    always_comb
    begin
        top_bit = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (max_c_reg[i])
            begin
                top_bit = 5'(i);
            end
        end
        for (int l = 0; l < 3; l++)
        begin
            if (top_bit >= 5'd29)
            begin
                nm_next[l] = 30'(mag_c_reg[l] >> (top_bit - 5'd29));
            end
            else
            begin
                nm_next[l] = 30'(mag_c_reg[l] << (5'd29 - top_bit));
            end
        end
    end

    // Squared length of the scaled axis
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nm_d_reg <= nm_next;
            for (int l = 0; l < 3; l++)
            begin
                sqn_e_reg[l] <= 60'(nm_d_reg[l]) * 60'(nm_d_reg[l]);
            end
            sum2_f_reg <= 62'(sqn_e_reg[0]) + 62'(sqn_e_reg[1]) + 62'(sqn_e_reg[2]);
        end
    end

    // Delay lines for data that bypasses the square root and divider rows
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nm_line_reg[0]   <= nm_d_reg;
            side_line_reg[0] <= side_c_reg;
            cq_line_reg[0]   <= cs_map;
            for (int k = 1; k < NM_DEPTH; k++)
            begin
                nm_line_reg[k] <= nm_line_reg[k-1];
            end
            for (int k = 1; k < SIDE_DEPTH; k++)
            begin
                side_line_reg[k] <= side_line_reg[k-1];
            end
            for (int k = 1; k < CQ_DEPTH; k++)
            begin
                cq_line_reg[k] <= cq_line_reg[k-1];
            end
        end
    end

    // Square root row, one result bit per cell
    assign slink[0].rem  = sum2_f_reg;
    assign slink[0].root = '0;

    for (genvar j = 0; j < qaar_pkg::SQRT_STEPS; j++)
    begin : g_sqrt
        qaar_sqrt_cell #(
            .K(qaar_pkg::SQRT_STEPS - 1 - j)
        ) u_cell (
            .clk  (clk),
            .en   (en),
            .d_in (slink[j]),
            .d_out(slink[j+1])
        );
    end

    // Rounded dividends for the three unit components
    assign len_g = slink[qaar_pkg::SQRT_STEPS].root[30:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 3; l++)
            begin
                div_g_reg[l].rem     <= {1'b0, nm_line_reg[NM_DEPTH-1][l], 30'd0} +
                                        61'(len_g >> 1);
                div_g_reg[l].divisor <= len_g;
                div_g_reg[l].quo     <= '0;
            end
        end
    end

    // Divider rows, one per axis component
    for (genvar l = 0; l < 3; l++)
    begin : g_lane
        assign dlink[l][0] = div_g_reg[l];
        for (genvar j = 0; j < qaar_pkg::DIV_STEPS; j++)
        begin : g_div
            qaar_div_cell #(
                .BIT(qaar_pkg::DIV_STEPS - 1 - j)
            ) u_cell (
                .clk  (clk),
                .en   (en),
                .d_in (dlink[l][j]),
                .d_out(dlink[l][j+1])
            );
        end
    end

    // Reduce the half-angle phase to a quadrant and a small residual
    assign phase = 32'(ang_a_reg) << (31 - qaar_pkg::ANGLE_BITS);
    assign quad  = 2'((phase + 32'h2000_0000) >> 30);
    assign resid = phase - {quad, 30'd0};

    assign clink[0].x    = qaar_pkg::CORDIC_X0;
    assign clink[0].y    = '0;
    assign clink[0].z    = CW'($signed(resid));
    assign clink[0].quad = quad;

    for (genvar k = 0; k < CORDIC_STAGES; k++)
    begin : g_cordic
        qaar_cordic_cell #(
            .STAGE(k)
        ) u_cell (
            .clk  (clk),
            .en   (en),
            .d_in (clink[k]),
            .d_out(clink[k+1])
        );
    end

    // Rotate the CORDIC result back into its quadrant
    assign cend = clink[CORDIC_STAGES];

    always_comb
    begin
        unique case (cend.quad)
            2'd0:
            begin
                cs_map.qw = 32'(cend.x);
                cs_map.qs = 32'(cend.y);
            end
            2'd1:
            begin
                cs_map.qw = 32'(-cend.y);
                cs_map.qs = 32'(cend.x);
            end
            2'd2:
            begin
                cs_map.qw = 32'(-cend.x);
                cs_map.qs = 32'(-cend.y);
            end
            default:
            begin
                cs_map.qw = 32'(cend.y);
                cs_map.qs = 32'(-cend.x);
            end
        endcase
    end

    // Vector part of the quaternion: sin(A/2) times the unit axis
    for (genvar l = 0; l < 3; l++)
    begin : g_qvec
        logic signed [31:0] unit;
        assign unit = side_line_reg[SIDE_DEPTH-1].neg[l] ?
                      -$signed({1'b0, dlink[l][qaar_pkg::DIV_STEPS].quo}) :
                      $signed({1'b0, dlink[l][qaar_pkg::DIV_STEPS].quo});
        assign qv_h[l] = qaar_pkg::mul_q(36'(cq_line_reg[CQ_DEPTH-1].qs), unit);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_h_reg[0] <= cq_line_reg[CQ_DEPTH-1].qw;
            for (int l = 0; l < 3; l++)
            begin
                q_h_reg[l+1] <= qv_h[l][31:0];
                pnt_h_reg[l] <= side_line_reg[SIDE_DEPTH-1].pnt[l];
            end
            zero_h_reg <= side_line_reg[SIDE_DEPTH-1].zero;
        end
    end

    // First Hamilton product: q * (0, p)
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int m = 0; m < 12; m++)
            begin
                m_i_reg[m] <= qaar_pkg::mul_q(36'(pnt_h_reg[PI_SEL[m]]), q_h_reg[QI_SEL[m]]);
            end
            q_i_reg    <= q_h_reg;
            pnt_i_reg  <= pnt_h_reg;
            zero_i_reg <= zero_h_reg;
        end
    end

    assign r_sum[0] = -(41'(m_i_reg[0]) + 41'(m_i_reg[1]) + 41'(m_i_reg[2]));
    assign r_sum[1] = 41'(m_i_reg[3]) + 41'(m_i_reg[4]) - 41'(m_i_reg[5]);
    assign r_sum[2] = 41'(m_i_reg[6]) + 41'(m_i_reg[7]) - 41'(m_i_reg[8]);
    assign r_sum[3] = 41'(m_i_reg[9]) + 41'(m_i_reg[10]) - 41'(m_i_reg[11]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 4; c++)
            begin
                r_j_reg[c] <= 36'(r_sum[c]);
            end
            q_j_reg    <= q_i_reg;
            pnt_j_reg  <= pnt_i_reg;
            zero_j_reg <= zero_i_reg;
        end
    end

    // Second Hamilton product: r * conj(q)
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int m = 0; m < 12; m++)
            begin
                n_k_reg[m] <= qaar_pkg::mul_q(r_j_reg[RI_SEL[m]], q_j_reg[QK_SEL[m]]);
            end
            pnt_k_reg  <= pnt_j_reg;
            zero_k_reg <= zero_j_reg;
        end
    end

    // Final sums and clipping to the coordinate range
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            res_sum[l] = -41'(n_k_reg[4*l]) + 41'(n_k_reg[4*l+1]) -
                         41'(n_k_reg[4*l+2]) + 41'(n_k_reg[4*l+3]);
            if (res_sum[l] > 41'sd2147483647)
            begin
                clip_val[l] = {1'b0, {(PW-1){1'b1}}};
                clip_hit[l] = 1'b1;
            end
            else if (res_sum[l] < -41'sd2147483648)
            begin
                clip_val[l] = {1'b1, {(PW-1){1'b0}}};
                clip_hit[l] = 1'b1;
            end
            else
            begin
                clip_val[l] = res_sum[l][PW-1:0];
                clip_hit[l] = 1'b0;
            end
        end
    end

    // Output register; a zero axis passes the point through
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 3; l++)
            begin
                rot_reg[l] <= zero_k_reg ? pnt_k_reg[l] : clip_val[l];
            end
            wz_reg  <= zero_k_reg;
            sat_reg <= !zero_k_reg && (|clip_hit);
        end
    end

    assign item_out.valid         = vld_reg[LAST];
    assign item_out.rotated_x     = rot_reg[0];
    assign item_out.rotated_y     = rot_reg[1];
    assign item_out.rotated_z     = rot_reg[2];
    assign item_out.axis_was_zero = wz_reg;
    assign item_out.saturated     = sat_reg;

`ifndef SYNTHESIS
    // The identity rotation never clips.
    a_zero_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        item_out.valid && item_out.axis_was_zero |-> !item_out.saturated)
        else $error("saturated raised on identity rotation");

    // A stalled pipeline keeps its result.
    a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        !item_in.ready |=> item_out.valid)
        else $error("result lost during stall");

    // A result only appears when the stage before it held a request.
    a_rise_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(item_out.valid) |-> $past(vld_reg[LAST-1]))
        else $error("result appeared from an empty stage");
`endif
endmodule
